@@ src/sfe_pkg.sv @@
// Shared types and constants for the stereo feedback echo.
// Used by sfe_ring_ram users, sfe_chan and stereo_feedback_echo.
`default_nettype none

package sfe_pkg;

    // Ring of past output frames; depth is a power of two
    localparam int RING_AW    = 15;
    localparam int RING_DEPTH = 1 << RING_AW;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int FRAC_W     = 15;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] DELAY_RESET = 16'd1;
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET  = 16'd0;
    localparam logic [GAIN_W-1:0]     GAIN_ONE    = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W:0]     gain_q_t;
    typedef logic [RING_AW-1:0]         ring_addr_t;
    typedef logic [FRAME_W-1:0]         frame_t;

    // Selection of the history sample seen by the multiply stage
    typedef struct packed {
        logic s2_hit;
        logic s3_hit;
        logic unwritten;
    } fwd_sel_t;

endpackage

`default_nettype wire

@@ src/stereo_feedback_echo.sv @@
// Stereo feedback echo: y = x + gain * y[n - delay] per channel, saturated.
// Accepted frames pass the stage 1, stage 2 and output registers before out_valid.
// Throughput: one frame per cycle; the whole pipeline holds while the output stalls.
// One ring read per advance and at most one write; in-flight results are forwarded.
// Reset: delay 1, gain 0, ring reads as zero until written (wrap flag, no clearing pass).
// Uses sfe_pkg, sfe_ring_ram and sfe_chan.
`default_nettype none

module stereo_feedback_echo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sfe_pkg::sample_t                   left_in,
    input  sfe_pkg::sample_t                   right_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sfe_pkg::sample_t                   left_out,
    output sfe_pkg::sample_t                   right_out
);

    import sfe_pkg::*;

    logic [CFG_DATA_W-1:0] delay_frames_reg;
    logic [GAIN_W-1:0]     decay_gain_reg;
    ring_addr_t            wp_reg;
    logic                  wrapped_reg;
    logic                  s1_valid_reg;
    ring_addr_t            s1_rp_reg;
    ring_addr_t            s1_wp_reg;
    logic                  s1_unwr_reg;
    logic                  s2_valid_reg;
    ring_addr_t            s2_wp_reg;
    ring_addr_t            s3_wp_reg;
    logic                  out_valid_reg;

    logic       adv;
    logic       accept;
    ring_addr_t rp;
    logic       rd_unwr;
    gain_q_t    gain_q;
    fwd_sel_t   sel;
    frame_t     rd_frame;
    frame_t     wr_frame;
    sample_t    left_calc;
    sample_t    right_calc;

    assign adv    = !out_valid_reg || out_ready;
    assign accept = in_valid && adv;

    assign rp      = wp_reg - RING_AW'(delay_frames_reg);
    assign rd_unwr = !(wrapped_reg || (rp < wp_reg));
    assign gain_q  = (decay_gain_reg > GAIN_ONE) ? gain_q_t'({1'b0, GAIN_ONE})
                                                 : gain_q_t'({1'b0, decay_gain_reg});

    always_comb
    begin
        sel.s2_hit    = s2_valid_reg && (s2_wp_reg == s1_rp_reg);
        sel.s3_hit    = out_valid_reg && (s3_wp_reg == s1_rp_reg);
        sel.unwritten = s1_unwr_reg;
    end

    assign wr_frame = {right_calc, left_calc};

    sfe_ring_ram #(
        .AW (RING_AW),
        .DW (FRAME_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (adv && s2_valid_reg),
        .wr_addr (s2_wp_reg),
        .wr_data (wr_frame),
        .rd_en   (adv),
        .rd_addr (rp),
        .rd_data (rd_frame)
    );

    sfe_chan u_left (
        .clk    (clk),
        .adv    (adv),
        .x_in   (left_in),
        .mem_h  (sample_t'(rd_frame[SAMPLE_W-1:0])),
        .sel    (sel),
        .gain   (gain_q),
        .y_calc (left_calc),
        .y_held (left_out)
    );

    sfe_chan u_right (
        .clk    (clk),
        .adv    (adv),
        .x_in   (right_in),
        .mem_h  (sample_t'(rd_frame[FRAME_W-1:SAMPLE_W])),
        .sel    (sel),
        .gain   (gain_q),
        .y_calc (right_calc),
        .y_held (right_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_frames_reg <= DELAY_RESET;
            decay_gain_reg   <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DELAY: delay_frames_reg <= cfg_data;
                REG_GAIN:  decay_gain_reg   <= GAIN_W'(cfg_data);
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_rp_reg     <= '0;
            s1_wp_reg     <= '0;
            s1_unwr_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_wp_reg     <= '0;
            s3_wp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (wp_reg == '1)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (adv)
            begin
                s1_valid_reg  <= in_valid;
                s1_rp_reg     <= rp;
                s1_wp_reg     <= wp_reg;
                s1_unwr_reg   <= rd_unwr;
                s2_valid_reg  <= s1_valid_reg;
                s2_wp_reg     <= s1_wp_reg;
                s3_wp_reg     <= s2_wp_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign in_ready  = adv;
    assign out_valid = out_valid_reg;

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_wp_step : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (wp_reg - $past(wp_reg)) == RING_AW'(1))
        else $error("write position did not advance by one");

    a_wp_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(wp_reg))
        else $error("write position moved without a transaction");

    a_wrap_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag cleared outside reset");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_valid_reg) && $stable(s2_valid_reg))
        else $error("pipeline moved while the output stalled");

    a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result shown without a transaction in the last stage");

endmodule

`default_nettype wire

@@ src/sfe_ring_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data registered, read-first on a same-address collision; no dependencies.
`default_nettype none

module sfe_ring_ram #(
    parameter int AW = 15,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [1 << AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/sfe_chan.sv @@
// One channel of the echo datapath: history select, gain multiply,
// truncating scale, saturating add and the output data register. Uses sfe_pkg.
`default_nettype none

module sfe_chan (
    input  logic              clk,
    input  logic              adv,
    input  sfe_pkg::sample_t  x_in,
    input  sfe_pkg::sample_t  mem_h,
    input  sfe_pkg::fwd_sel_t sel,
    input  sfe_pkg::gain_q_t  gain,
    output sfe_pkg::sample_t  y_calc,
    output sfe_pkg::sample_t  y_held
);

    import sfe_pkg::*;

    localparam int QUOT_W = PROD_W - FRAC_W;
    localparam int SUM_W  = QUOT_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << FRAC_W) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI     = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_LO     = -SUM_W'(1 << (SAMPLE_W - 1));

    sample_t                   x_s1_reg;
    sample_t                   x_s2_reg;
    logic signed [PROD_W-1:0]  prod_s2_reg;
    logic signed [PROD_W-1:0]  prod_next;
    sample_t                   y_out_reg;
    sample_t                   h_sel;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [SUM_W-1:0]   sum;

    always_comb
    begin
        if (sel.s2_hit)
        begin
            h_sel = y_calc;
        end
        else if (sel.s3_hit)
        begin
            h_sel = y_out_reg;
        end
        else if (sel.unwritten)
        begin
            h_sel = '0;
        end
        else
        begin
            h_sel = mem_h;
        end
        prod_next = PROD_W'(h_sel) * PROD_W'(gain);
    end

    always_comb
    begin
        prod_adj = prod_s2_reg + (prod_s2_reg[PROD_W-1] ? ROUND_BIAS : '0);
        quot     = prod_adj[PROD_W-1:FRAC_W];
        sum      = SUM_W'(x_s2_reg) + SUM_W'(quot);
        if (sum > SAT_HI)
        begin
            y_calc = SAMPLE_W'(SAT_HI);
        end
        else if (sum < SAT_LO)
        begin
            y_calc = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            y_calc = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_s1_reg    <= x_in;
            x_s2_reg    <= x_s1_reg;
            prod_s2_reg <= prod_next;
            y_out_reg   <= y_calc;
        end
    end

    assign y_held = y_out_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for stereo_feedback_echo: directed table then random frames, checked against
// listed values or an in-bench feedback comb predictor. Depends on sfe_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import sfe_pkg::*;

    typedef struct packed {
        sample_t l;
        sample_t r;
    } frame_pair_t;

    typedef struct packed {
        logic                  cfg;
        logic [CFG_DATA_W-1:0] delay;
        logic [CFG_DATA_W-1:0] gain;
        sample_t               l;
        sample_t               r;
        logic                  typed;
        sample_t               el;
        sample_t               er;
    } stim_row_t;

    localparam int N_DIRECTED = 21;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, 16'd0, 16'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{1'b0, 16'd0, 16'd0, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768},
        '{1'b0, 16'd0, 16'd0, -16'sd32768, 16'sd32767, 1'b1, -16'sd32768, 16'sd32767},
        '{1'b0, 16'd0, 16'd0, -16'sd1, 16'sd1, 1'b1, -16'sd1, 16'sd1},
        '{1'b0, 16'd0, 16'd0, 16'sd21845, -16'sd21846, 1'b1, 16'sd21845, -16'sd21846},
        '{1'b1, 16'd1, 16'd32768, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768},
        '{1'b0, 16'd0, 16'd0, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768},
        '{1'b0, 16'd0, 16'd0, 16'sd0, 16'sd0, 1'b1, 16'sd32767, -16'sd32768},
        '{1'b0, 16'd0, 16'd0, -16'sd32768, 16'sd32767, 1'b1, -16'sd1, -16'sd1},
        '{1'b1, 16'd1, 16'd1, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{1'b0, 16'd0, 16'd0, -16'sd32768, 16'sd32767, 1'b1, -16'sd32768, 16'sd32767},
        '{1'b0, 16'd0, 16'd0, 16'sd5, -16'sd5, 1'b1, 16'sd4, -16'sd5},
        '{1'b1, 16'd2, 16'd16384, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd0, 16'd0, 16'sd7, -16'sd7, 1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'd40000, 16'd40000, 16'sd1234, -16'sd4321, 1'b1, 16'sd1234, -16'sd4321},
        '{1'b1, 16'd32767, 16'd65535, -16'sd32768, 16'sd32767, 1'b1, -16'sd32768,
          16'sd32767},
        '{1'b1, 16'd0, 16'd32768, 16'sd32767, 16'sd32767, 1'b1, 16'sd32767, 16'sd32767},
        '{1'b1, 16'd32768, 16'd32767, -16'sd1, -16'sd32768, 1'b1, -16'sd1, -16'sd32768},
        '{1'b1, 16'd65535, 16'd0, 16'sd12345, -16'sd12345, 1'b1, 16'sd12345, -16'sd12345},
        '{1'b1, 16'd3, 16'd32768, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd0, 16'd0, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0}
    };

    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 40;
    localparam logic [CFG_DATA_W-1:0] PHASE_DELAY [N_PHASES] =
        '{16'd1, 16'd2, 16'd3, 16'd5, 16'd17, 16'd31, 16'd0, 16'd0};
    localparam logic [CFG_DATA_W-1:0] PHASE_GAIN [N_PHASES] =
        '{16'd32768, 16'd16384, 16'd32767, 16'd40000, 16'd65535, 16'd1, 16'd0, 16'd0};

    localparam int TAIL_ITEMS = 15;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    sample_t               left_in = '0;
    sample_t               right_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sample_t               left_out;
    sample_t               right_out;

    // predictor state
    frame_t                echo_history [RING_DEPTH];
    ring_addr_t            echo_wr_pos = '0;
    logic [CFG_DATA_W-1:0] echo_delay = DELAY_RESET;
    logic [CFG_DATA_W-1:0] echo_gain = GAIN_RESET;

    frame_pair_t pending_frames [$];
    int          error_count = 0;
    int          frames_sent = 0;
    int          frames_checked = 0;
    int          cfg_writes = 0;
    logic        calm = 1'b0;
    int          hold_left = 0;
    logic        held_once = 1'b0;

    stereo_feedback_echo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #8000000;
        $display("[stereo_feedback_echo] ERROR");
        $finish;
    end

    function automatic sample_t echo_sample(sample_t x, sample_t h, logic [GAIN_W:0] g);
        int prod;
        int sum;
        prod = int'(h) * int'(g);
        sum = int'(x) + prod / 32768;
        if (sum > 32767)
            sum = 32767;
        if (sum < -32768)
            sum = -32768;
        return sum[SAMPLE_W-1:0];
    endfunction

    task automatic advance_echo(input sample_t l, input sample_t r,
                                output sample_t el, output sample_t er);
        ring_addr_t      rd;
        logic [GAIN_W:0] g;
        frame_t          past;
        rd = echo_wr_pos - echo_delay[RING_AW-1:0];
        past = echo_history[rd];
        g = (echo_gain > GAIN_ONE) ? {1'b0, GAIN_ONE} : {1'b0, echo_gain};
        el = echo_sample(l, past[SAMPLE_W-1:0], g);
        er = echo_sample(r, past[FRAME_W-1:SAMPLE_W], g);
        echo_history[echo_wr_pos] = {er, el};
        echo_wr_pos = echo_wr_pos + 1'b1;
    endtask

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    function automatic sample_t random_sample();
        int mode;
        mode = $urandom_range(9);
        case (mode)
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return sample_t'($urandom_range(511)) - 16'sd256;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // offer one frame, hold it until the transaction completes, then predict
    task automatic offer_frame(input sample_t l, input sample_t r, input logic typed,
                               input sample_t el_typed, input sample_t er_typed);
        sample_t el;
        sample_t er;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do
            @(posedge clk);
        while (!in_ready);
        advance_echo(l, r, el, er);
        if (typed)
            pending_frames.push_back('{el_typed, er_typed});
        else
            pending_frames.push_back('{el, er});
        frames_sent++;
    endtask

    // drop valid and wait for every expected frame, plus the pipeline latency
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DELAY)
            echo_delay = data;
        else
            echo_gain = data;
        cfg_writes++;
    endtask

    task automatic run_random(input logic [CFG_DATA_W-1:0] delay,
                              input logic [CFG_DATA_W-1:0] gain, input int count);
        settle_block();
        write_reg(REG_DELAY, delay);
        write_reg(REG_GAIN, gain);
        for (int i = 0; i < count; i++)
            offer_frame(random_sample(), random_sample(), 1'b0, '0, '0);
    endtask

    // receiver: random back-pressure when not calm, one long hold-off to fill the pipeline
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!held_once && frames_checked >= 120)
        begin
            held_once = 1'b1;
            hold_left = 90;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        frame_pair_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
                note_failure($sformatf("unexpected frame L=%0d R=%0d", left_out, right_out));
            else
            begin
                due = pending_frames.pop_front();
                if (left_out !== due.l)
                    note_failure($sformatf("frame %0d left_out: expected %0d, got %0d",
                                           frames_checked, due.l, left_out));
                if (right_out !== due.r)
                    note_failure($sformatf("frame %0d right_out: expected %0d, got %0d",
                                           frames_checked, due.r, right_out));
            end
            frames_checked++;
        end
    end

    initial
    begin
        foreach (echo_history[i])
            echo_history[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].cfg)
            begin
                settle_block();
                write_reg(REG_DELAY, DIRECTED[i].delay);
                write_reg(REG_GAIN, DIRECTED[i].gain);
            end
            offer_frame(DIRECTED[i].l, DIRECTED[i].r, DIRECTED[i].typed,
                        DIRECTED[i].el, DIRECTED[i].er);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            calm = (p == 3);
            if (p == N_PHASES - 2)
                run_random(16'($urandom_range(64, 1)), 16'($urandom_range(32768)),
                           PHASE_ITEMS);
            else if (p == N_PHASES - 1)
                run_random(16'($urandom_range(300, 1)), 16'($urandom), PHASE_ITEMS);
            else
                run_random(PHASE_DELAY[p], PHASE_GAIN[p], PHASE_ITEMS);
        end
        calm = 1'b0;

        // delays of zero and of the ring depth or more read slots not yet written
        run_random(16'd0, 16'd24576, TAIL_ITEMS);
        run_random(16'd32768, 16'd30000, TAIL_ITEMS);
        run_random(16'd65535, 16'd32768, TAIL_ITEMS);
        run_random(16'd40000, 16'd20000, TAIL_ITEMS);

        settle_block();
        repeat (8) @(posedge clk);

        if (pending_frames.size() != 0)
            note_failure($sformatf("%0d frames never came out", pending_frames.size()));
        $display("Sent %0d stereo frames, checked %0d outputs, %0d register writes,",
                 frames_sent, frames_checked, cfg_writes);
        $display("covering saturation, truncation, gain clamp and long delays; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("[stereo_feedback_echo] OK");
        else
            $display("[stereo_feedback_echo] ERROR");
        $finish;
    end

endmodule
